>>> design/double_ended_queue_defines.svh
// ----------------------------------------------------------------------------
// Double-ended queue assertion macros
// Shared concurrent assertion forms for the queue modules.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define DEQ_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define DEQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> design/deq_pkg.sv
// ----------------------------------------------------------------------------
// Double-ended queue package
// Action and status codes, field widths and the command passed front to back.
// ----------------------------------------------------------------------------
package deq_pkg;

   localparam int WORD_W    = 32;
   localparam int ACT_W     = 3;
   localparam int STAT_W    = 2;
   localparam int OCC_W     = 11;
   // widest store index over the supported depth range
   localparam int PTR_MAX_W = 16;

   localparam logic [WORD_W-1:0] NONE_WORD = '1;

   typedef enum logic [ACT_W-1:0] {
      ACT_PUSH_FRONT = 3'd0,
      ACT_PUSH_BACK  = 3'd1,
      ACT_POP_FRONT  = 3'd2,
      ACT_POP_BACK   = 3'd3,
      ACT_QUERY      = 3'd4
   } action_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK    = 2'd0,
      STAT_EMPTY = 2'd1,
      STAT_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      logic                 wr_en;
      logic [PTR_MAX_W-1:0] wr_addr;
      logic [WORD_W-1:0]    wr_data;
      logic                 pop_ok;
      logic [PTR_MAX_W-1:0] pop_addr;
      logic [PTR_MAX_W-1:0] head_addr;
      logic [PTR_MAX_W-1:0] tail_addr;
      status_type           status;
      logic [OCC_W-1:0]     occupancy;
      logic                 empty_flag;
   } op_type;

endpackage

>>> design/deq_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered, enabled read data.
// ----------------------------------------------------------------------------
module deq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/deq_front.sv
// ----------------------------------------------------------------------------
// Double-ended queue front end
// Accepts actions, updates head index and count, and issues store commands.
// ----------------------------------------------------------------------------
`include "double_ended_queue_defines.svh"

module deq_front #(
   parameter int DEPTH = 1024
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [deq_pkg::ACT_W-1:0]    req_action,
   input  logic signed [deq_pkg::WORD_W-1:0] req_push_value,
   input  logic                         cmd_full,
   output logic                         cmd_push,
   output deq_pkg::op_type              cmd_op
);
   import deq_pkg::*;

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int SUM_W = CNT_W + 1;
   localparam logic [SUM_W-1:0] DEPTH_S = SUM_W'(DEPTH);
   localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

   logic [IDX_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             accept;
   logic             full, empty;
   logic [IDX_W-1:0] head_m1, head_p1, back_idx, append_idx, tail_idx;
   logic [IDX_W-1:0] wr_idx, pop_idx;
   logic             wr_en, pop_ok;
   status_type       status;

   // reduce a position below twice the depth into the ring
   function automatic logic [IDX_W-1:0] wrap_idx(input logic [SUM_W-1:0] p);
      if (p >= DEPTH_S) begin
         return IDX_W'(p - DEPTH_S);
      end
      return IDX_W'(p);
   endfunction

   assign req_stall = cmd_full;
   assign accept    = req_valid && !req_stall;
   assign full      = (count_ff == DEPTH_C);
   assign empty     = (count_ff == '0);

   // neighbor positions of the current ends
   assign head_m1 = (head_ff == '0) ? IDX_W'(DEPTH - 1) : head_ff - 1'b1;
   assign head_p1 = wrap_idx(SUM_W'(head_ff) + SUM_W'(1));
   assign append_idx = wrap_idx(SUM_W'(head_ff) + SUM_W'(count_ff));
   assign back_idx = wrap_idx(SUM_W'(head_ff) + SUM_W'(count_ff) - SUM_W'(1));

   // classify the action and work out the next head and count
   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      wr_en    = 1'b0;
      pop_ok   = 1'b0;
      wr_idx   = head_ff;
      pop_idx  = head_ff;
      status   = STAT_OK;
      case (action_type'(req_action))
         ACT_PUSH_FRONT: begin
            if (full) begin
               status = STAT_FULL;
            end else begin
               head_in  = head_m1;
               wr_idx   = head_m1;
               wr_en    = 1'b1;
               count_in = count_ff + 1'b1;
            end
         end
         ACT_PUSH_BACK: begin
            if (full) begin
               status = STAT_FULL;
            end else begin
               wr_idx   = append_idx;
               wr_en    = 1'b1;
               count_in = count_ff + 1'b1;
            end
         end
         ACT_POP_FRONT: begin
            if (empty) begin
               status = STAT_EMPTY;
            end else begin
               pop_idx  = head_ff;
               pop_ok   = 1'b1;
               head_in  = head_p1;
               count_in = count_ff - 1'b1;
            end
         end
         ACT_POP_BACK: begin
            if (empty) begin
               status = STAT_EMPTY;
            end else begin
               pop_idx  = back_idx;
               pop_ok   = 1'b1;
               count_in = count_ff - 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // back end of the queue after this action
   assign tail_idx = wrap_idx(SUM_W'(head_in) + SUM_W'(count_in) - SUM_W'(1));

   // build the store command
   always_comb begin
      cmd_op.wr_en      = wr_en;
      cmd_op.wr_addr    = PTR_MAX_W'(wr_idx);
      cmd_op.wr_data    = req_push_value;
      cmd_op.pop_ok     = pop_ok;
      cmd_op.pop_addr   = PTR_MAX_W'(pop_idx);
      cmd_op.head_addr  = PTR_MAX_W'(head_in);
      cmd_op.tail_addr  = PTR_MAX_W'(tail_idx);
      cmd_op.status     = status;
      cmd_op.occupancy  = OCC_W'(count_in);
      cmd_op.empty_flag = (count_in == '0);
   end

   assign cmd_push = accept;

   // advance queue state on each transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else if (accept) begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   `DEQ_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= DEPTH_C,
      "word count above depth")
   `DEQ_ASSERT_NEXT(a_push_counts, clock, reset, accept && wr_en,
      count_ff == $past(count_ff) + 1'b1, "accepted push did not raise count")
   `DEQ_ASSERT_NEXT(a_pop_counts, clock, reset, accept && pop_ok,
      count_ff == $past(count_ff) - 1'b1, "accepted pop did not lower count")

endmodule

>>> design/deq_cmd_fifo.sv
// ----------------------------------------------------------------------------
// Double-ended queue command queue
// Two-entry queue of store commands between the front and back ends.
// ----------------------------------------------------------------------------
module deq_cmd_fifo (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  deq_pkg::op_type push_op,
   input  logic            pop,
   output logic            full,
   output logic            empty,
   output deq_pkg::op_type head_op
);
   import deq_pkg::*;

   op_type      entry_ff [2];
   logic        wr_ptr_ff, rd_ptr_ff;
   logic [1:0]  count_ff;

   assign full    = (count_ff == 2'd2);
   assign empty   = (count_ff == 2'd0);
   assign head_op = entry_ff[rd_ptr_ff];

   // hold entries
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_op;
      end
   end

   // advance pointers and count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 2'd1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 2'd1;
         end
      end
   end

endmodule

>>> design/deq_back.sv
// ----------------------------------------------------------------------------
// Double-ended queue back end
// Executes store commands and reads popped, front and back words.
// ----------------------------------------------------------------------------
`include "double_ended_queue_defines.svh"

module deq_back #(
   parameter int DEPTH = 1024
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               cmd_empty,
   input  deq_pkg::op_type                    cmd_op,
   output logic                               cmd_pop,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [deq_pkg::STAT_W-1:0]         rsp_status,
   output logic signed [deq_pkg::WORD_W-1:0]  rsp_popped_value,
   output logic [deq_pkg::OCC_W-1:0]          rsp_occupancy,
   output logic                               rsp_is_empty,
   output logic signed [deq_pkg::WORD_W-1:0]  rsp_head_value,
   output logic signed [deq_pkg::WORD_W-1:0]  rsp_tail_value
);
   import deq_pkg::*;

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_HEAD = 4'b0010,
      ST_TAIL = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

   state_type         state_ff, state_in;
   op_type            op_ff, op_in;
   logic [WORD_W-1:0] popped_ff, popped_in;
   logic [WORD_W-1:0] head_word_ff, head_word_in;
   logic              rd_en;
   logic [IDX_W-1:0]  rd_addr;
   logic [WORD_W-1:0] rd_data;
   logic              wr_en;
   logic              out_free, load;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0]        rsp_status_ff;
   logic [WORD_W-1:0]        rsp_popped_ff, rsp_head_ff, rsp_tail_ff;
   logic [OCC_W-1:0]         rsp_occ_ff;
   logic                     rsp_empty_ff;

   deq_ram #(
      .WIDTH (WORD_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (cmd_op.wr_addr[IDX_W-1:0]),
      .wr_data (cmd_op.wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // sequence write, popped read, front read and back read
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      popped_in    = popped_ff;
      head_word_in = head_word_ff;
      cmd_pop      = 1'b0;
      wr_en        = 1'b0;
      rd_en        = 1'b0;
      rd_addr      = op_ff.head_addr[IDX_W-1:0];
      load         = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (!cmd_empty) begin
               cmd_pop  = 1'b1;
               op_in    = cmd_op;
               wr_en    = cmd_op.wr_en;
               rd_en    = 1'b1;
               rd_addr  = cmd_op.pop_addr[IDX_W-1:0];
               state_in = ST_HEAD;
            end
         end
         ST_HEAD: begin
            popped_in = rd_data;
            rd_en     = 1'b1;
            rd_addr   = op_ff.head_addr[IDX_W-1:0];
            state_in  = ST_TAIL;
         end
         ST_TAIL: begin
            head_word_in = rd_data;
            rd_en        = 1'b1;
            rd_addr      = op_ff.tail_addr[IDX_W-1:0];
            state_in     = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               load     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // drop the result on transfer, set it on load
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // hold the command and captured words
   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      popped_ff    <= popped_in;
      head_word_ff <= head_word_in;
      if (load) begin
         rsp_status_ff <= op_ff.status;
         rsp_popped_ff <= op_ff.pop_ok ? popped_ff : NONE_WORD;
         rsp_occ_ff    <= op_ff.occupancy;
         rsp_empty_ff  <= op_ff.empty_flag;
         rsp_head_ff   <= op_ff.empty_flag ? NONE_WORD : head_word_ff;
         rsp_tail_ff   <= op_ff.empty_flag ? NONE_WORD : rd_data;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_popped_value = rsp_popped_ff;
   assign rsp_occupancy    = rsp_occ_ff;
   assign rsp_is_empty     = rsp_empty_ff;
   assign rsp_head_value   = rsp_head_ff;
   assign rsp_tail_value   = rsp_tail_ff;

   `DEQ_ASSERT_NEXT(a_cmd_starts, clock, reset, cmd_pop, state_ff == ST_HEAD,
      "command taken without starting the read sequence")
   `DEQ_ASSERT_NEXT(a_done_loads, clock, reset, load, rsp_valid_ff,
      "finished command did not raise a result")
   `DEQ_ASSERT_NOW(a_empty_ends, clock, reset, rsp_valid_ff && rsp_empty_ff,
      rsp_head_ff == NONE_WORD && rsp_tail_ff == NONE_WORD,
      "empty result shows a front or back word")
   `DEQ_ASSERT_NOW(a_fail_no_pop, clock, reset,
      rsp_valid_ff && rsp_status_ff != STAT_OK, rsp_popped_ff == NONE_WORD,
      "failed action reports a popped word")

endmodule

>>> design/double_ended_queue.sv
// ----------------------------------------------------------------------------
// Double-ended queue
// Bounded ring-buffer deque of signed words with push and pop at both ends.
//
//   Channel   Ports                         Direction
//   req       req_valid / req_stall         in   action, push_value
//   rsp       rsp_valid / rsp_stall         out  status, popped word, count,
//                                                empty flag, front, back
//
// The back end handles one action at a time: the store has one read port,
// so the popped word, the front word and the back word are read in turn.
// The front end updates head and count at transfer and runs up to two
// actions ahead through the command queue. Reset is synchronous; the store
// needs no clearing pass. A stalled result holds while the next action reads.
// ----------------------------------------------------------------------------
module double_ended_queue #(
   parameter int DEPTH = 1024
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [deq_pkg::ACT_W-1:0]          req_action,
   input  logic signed [deq_pkg::WORD_W-1:0]  req_push_value,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [deq_pkg::STAT_W-1:0]         rsp_status,
   output logic signed [deq_pkg::WORD_W-1:0]  rsp_popped_value,
   output logic [deq_pkg::OCC_W-1:0]          rsp_occupancy,
   output logic                               rsp_is_empty,
   output logic signed [deq_pkg::WORD_W-1:0]  rsp_head_value,
   output logic signed [deq_pkg::WORD_W-1:0]  rsp_tail_value
);
   import deq_pkg::*;

   logic   cmd_push, cmd_pop, cmd_full, cmd_empty;
   op_type cmd_in_op, cmd_out_op;

   deq_front #(
      .DEPTH (DEPTH)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_action     (req_action),
      .req_push_value (req_push_value),
      .cmd_full       (cmd_full),
      .cmd_push       (cmd_push),
      .cmd_op         (cmd_in_op)
   );

   deq_cmd_fifo u_cmd_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (cmd_push),
      .push_op (cmd_in_op),
      .pop     (cmd_pop),
      .full    (cmd_full),
      .empty   (cmd_empty),
      .head_op (cmd_out_op)
   );

   deq_back #(
      .DEPTH (DEPTH)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .cmd_empty        (cmd_empty),
      .cmd_op           (cmd_out_op),
      .cmd_pop          (cmd_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_popped_value (rsp_popped_value),
      .rsp_occupancy    (rsp_occupancy),
      .rsp_is_empty     (rsp_is_empty),
      .rsp_head_value   (rsp_head_value),
      .rsp_tail_value   (rsp_tail_value)
   );

endmodule

>>> tb/sv/tb.sv
// ----------------------------------------------------------------------------
// Double-ended queue testbench
// Drives push, pop and query actions into the deque, tracks a shadow ring
// buffer to predict every result, and checks each response field by field
// while both sides of the handshake idle and stall in random bursts.
// ----------------------------------------------------------------------------
module tb;
   import deq_pkg::*;

   localparam int QUEUE_DEPTH = 1024;
   localparam int SETTLE_CYCLES = 40;
   localparam logic [ACT_W-1:0] ACT_SPARE_LO = 3'd5;
   localparam logic [ACT_W-1:0] ACT_SPARE_HI = 3'd7;
   localparam logic [WORD_W-1:0] WORD_MIN = 32'h8000_0000;
   localparam logic [WORD_W-1:0] WORD_MAX = 32'h7fff_ffff;

   typedef struct packed {
      status_type        status;
      logic [WORD_W-1:0] popped;
      logic [OCC_W-1:0]  occupancy;
      logic              empty_flag;
      logic [WORD_W-1:0] front_word;
      logic [WORD_W-1:0] back_word;
   } deque_result_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [ACT_W-1:0]          req_action = ACT_QUERY;
   logic signed [WORD_W-1:0]  req_push_value = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [STAT_W-1:0]         rsp_status;
   logic signed [WORD_W-1:0]  rsp_popped_value;
   logic [OCC_W-1:0]          rsp_occupancy;
   logic                      rsp_is_empty;
   logic signed [WORD_W-1:0]  rsp_head_value;
   logic signed [WORD_W-1:0]  rsp_tail_value;

   // shadow copy of the ring buffer
   logic [WORD_W-1:0] shadow_words [QUEUE_DEPTH];
   int unsigned       shadow_head = 0;
   int unsigned       shadow_count = 0;

   deque_result_type pending_results [$];
   int               error_count = 0;
   bit               sender_idles = 1'b0;
   bit               receiver_stalls = 1'b0;
   int               stall_left = 0;

   double_ended_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_action       (req_action),
      .req_push_value   (req_push_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_popped_value (rsp_popped_value),
      .rsp_occupancy    (rsp_occupancy),
      .rsp_is_empty     (rsp_is_empty),
      .rsp_head_value   (rsp_head_value),
      .rsp_tail_value   (rsp_tail_value)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Apply one action to the shadow buffer and return the response it gives
   function automatic deque_result_type predict_deque_step(logic [ACT_W-1:0] act,
                                                          logic [WORD_W-1:0] value);
      deque_result_type res;
      int unsigned      slot;
      res.status = STAT_OK;
      res.popped = NONE_WORD;
      case (act)
         ACT_PUSH_FRONT: begin
            if (shadow_count == QUEUE_DEPTH) begin
               res.status = STAT_FULL;
            end else begin
               shadow_head = (shadow_head == 0) ? QUEUE_DEPTH - 1 : shadow_head - 1;
               shadow_words[shadow_head] = value;
               shadow_count++;
            end
         end
         ACT_PUSH_BACK: begin
            if (shadow_count == QUEUE_DEPTH) begin
               res.status = STAT_FULL;
            end else begin
               slot = (shadow_head + shadow_count) % QUEUE_DEPTH;
               shadow_words[slot] = value;
               shadow_count++;
            end
         end
         ACT_POP_FRONT: begin
            if (shadow_count == 0) begin
               res.status = STAT_EMPTY;
            end else begin
               res.popped = shadow_words[shadow_head];
               shadow_head = (shadow_head + 1) % QUEUE_DEPTH;
               shadow_count--;
            end
         end
         ACT_POP_BACK: begin
            if (shadow_count == 0) begin
               res.status = STAT_EMPTY;
            end else begin
               slot = (shadow_head + shadow_count - 1) % QUEUE_DEPTH;
               res.popped = shadow_words[slot];
               shadow_count--;
            end
         end
         // query and the spare codes leave the queue alone
         default: ;
      endcase
      res.occupancy  = shadow_count[OCC_W-1:0];
      res.empty_flag = (shadow_count == 0);
      if (shadow_count == 0) begin
         res.front_word = NONE_WORD;
         res.back_word  = NONE_WORD;
      end else begin
         res.front_word = shadow_words[shadow_head];
         res.back_word  = shadow_words[(shadow_head + shadow_count - 1) % QUEUE_DEPTH];
      end
      return res;
   endfunction

   // Offer one action, hold it until the transfer, then record its response
   task automatic send_action(logic [ACT_W-1:0] act, logic [WORD_W-1:0] value);
      int               gap;
      deque_result_type expected;
      if (sender_idles && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 12);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_action     <= act;
      req_push_value <= value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected = predict_deque_step(act, value);
      pending_results = {pending_results, expected};
   endtask

   task automatic wait_all_answered();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   function automatic logic [WORD_W-1:0] pick_word();
      case ($urandom_range(0, 11))
         0:       return WORD_MIN;
         1:       return WORD_MAX;
         2:       return '0;
         3:       return NONE_WORD;
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [ACT_W-1:0] pick_push();
      return $urandom_range(0, 1) ? ACT_PUSH_BACK : ACT_PUSH_FRONT;
   endfunction

   function automatic logic [ACT_W-1:0] pick_pop();
      return $urandom_range(0, 1) ? ACT_POP_BACK : ACT_POP_FRONT;
   endfunction

   // Empty-queue pops, extreme words, alternating bit patterns, spare codes
   task automatic test_edge_actions();
      logic [ACT_W-1:0] code;
      send_action(ACT_QUERY, '0);
      send_action(ACT_POP_FRONT, '0);
      send_action(ACT_POP_BACK, '0);
      send_action(ACT_PUSH_FRONT, WORD_MIN);
      send_action(ACT_PUSH_BACK, WORD_MAX);
      send_action(ACT_PUSH_FRONT, '0);
      send_action(ACT_PUSH_BACK, NONE_WORD);
      send_action(ACT_PUSH_FRONT, 32'haaaa_aaaa);
      send_action(ACT_PUSH_BACK, 32'h5555_5555);
      send_action(ACT_QUERY, 32'h1234_5678);
      for (code = ACT_SPARE_LO; code <= ACT_SPARE_HI; code++) begin
         send_action(code, 32'hdead_beef);
         if (code == ACT_SPARE_HI) break;
      end
      send_action(ACT_POP_FRONT, 32'h0bad_cafe);
      send_action(ACT_POP_BACK, '0);
      send_action(ACT_POP_FRONT, '0);
      send_action(ACT_POP_BACK, '0);
      send_action(ACT_POP_FRONT, '0);
      send_action(ACT_POP_BACK, '0);
      send_action(ACT_POP_BACK, '0);
      send_action(ACT_QUERY, '0);
   endtask

   // Fill to capacity, then push against the full queue
   task automatic test_fill_to_full();
      sender_idles    = 1'b1;
      receiver_stalls = 1'b1;
      while (shadow_count < QUEUE_DEPTH) send_action(pick_push(), pick_word());
      // hold off until the full queue is visible in every response
      wait_all_answered();
      send_action(ACT_PUSH_FRONT, pick_word());
      send_action(ACT_PUSH_BACK, pick_word());
      send_action(ACT_QUERY, '0);
   endtask

   // Random walk of the occupancy, growing and shrinking in segments
   task automatic test_random_mix(int items);
      int               pick;
      int               push_pct;
      logic [ACT_W-1:0] act;
      for (int i = 0; i < items; i++) begin
         if (i % 150 == 0) begin
            sender_idles    = $urandom_range(0, 3) != 0;
            receiver_stalls = $urandom_range(0, 3) != 0;
         end
         // quiet tail: no idling on either side
         if (i >= items - 150) begin
            sender_idles    = 1'b0;
            receiver_stalls = 1'b0;
         end
         push_pct = ((i / 150) % 2 == 0) ? 55 : 30;
         pick = $urandom_range(0, 99);
         if (pick < 4) begin
            act = $urandom_range(ACT_SPARE_LO, ACT_SPARE_HI);
         end else if (pick < 10) begin
            act = ACT_QUERY;
         end else if (pick < 10 + push_pct) begin
            act = pick_push();
         end else begin
            act = pick_pop();
         end
         send_action(act, pick_word());
      end
   endtask

   // Random stall bursts on the response side
   always @(posedge clock) begin
      if (reset || !receiver_stalls) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 1) begin
         stall_left <= stall_left - 1;
      end else if (stall_left == 1) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if ($urandom_range(0, 4) == 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= $urandom_range(1, 12);
      end
   end

   task automatic check_field(string label, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch: expected %0h, got %0h", $time, label, want, got);
         error_count++;
      end
   endtask

   // Compare each response transfer against the oldest prediction
   always @(posedge clock) begin : rsp_check
      deque_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected response: expected none, got status %0h occupancy %0d",
                     $time, rsp_status, rsp_occupancy);
            error_count++;
         end else begin
            want = pending_results[0];
            pending_results.delete(0);
            check_field("status", want.status, rsp_status);
            check_field("popped_value", want.popped, rsp_popped_value);
            check_field("occupancy", want.occupancy, rsp_occupancy);
            check_field("empty_flag", want.empty_flag, rsp_is_empty);
            check_field("head_value", want.front_word, rsp_head_value);
            check_field("tail_value", want.back_word, rsp_tail_value);
         end
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_edge_actions();
      test_fill_to_full();
      test_random_mix(40);
      wait_all_answered();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_results.size() == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

   // Run limit
   initial begin
      #5_000_000;
      $display("%0t: timeout with %0d responses outstanding", $time, pending_results.size());
      $display("tb: done, errors");
      $finish;
   end

endmodule
